// ===== hw/rtl/vector_reflect_2d_top_defines.svh =====
// assertion macros used by the checker file
`ifndef VECTOR_REFLECT_2D_TOP_DEFINES_SVH
`define VECTOR_REFLECT_2D_TOP_DEFINES_SVH

// clocked assertion, off while reset is held
`define VR2D_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define VR2D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/vr2d_pkg.sv =====
// shared types and constants of the 2d vector reflection block
package vr2d_pkg;

    localparam int WORD_BITS = 32;
    localparam int UNIT_BITS = 29;
    localparam int SQRT_CELLS = 32;
    localparam int DIV_CELLS = 33;
    localparam int NORM_STEPS = 5;

    // remainder seed of the reciprocal: top bits of 2^62 above the quotient
    localparam logic [32:0] DIV_REM0 = 33'h0_2000_0000;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] vx;
        logic signed [WORD_BITS-1:0] vy;
        logic [30:0]                 ax;
        logic [30:0]                 ay;
        logic                        neg_x;
        logic                        neg_y;
        logic                        zero;
    } t_side;

    typedef struct packed {
        logic [63:0] res;
        logic [63:0] rem;
        t_side       side;
    } t_sq;

    typedef struct packed {
        logic [32:0] rem;
        logic [32:0] q;
        logic [31:0] mag;
        t_side       side;
    } t_dv;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] refl_x;
        logic signed [WORD_BITS-1:0] refl_y;
        logic                        normal_zero;
        logic                        saturated;
    } t_res;

endpackage

// ===== hw/rtl/vr2d_if.sv =====
// item channels of the 2d vector reflection block
interface vr2d_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [vr2d_pkg::WORD_BITS-1:0] vel_x;
    logic signed [vr2d_pkg::WORD_BITS-1:0] vel_y;
    logic signed [vr2d_pkg::WORD_BITS-1:0] normal_x;
    logic signed [vr2d_pkg::WORD_BITS-1:0] normal_y;

    modport source (output valid, output vel_x, output vel_y, output normal_x,
                    output normal_y, input ready);
    modport sink (input valid, input vel_x, input vel_y, input normal_x,
                  input normal_y, output ready);
endinterface

interface vr2d_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [vr2d_pkg::WORD_BITS-1:0] refl_x;
    logic signed [vr2d_pkg::WORD_BITS-1:0] refl_y;
    logic                                  normal_zero;
    logic                                  saturated;

    modport source (output valid, output refl_x, output refl_y, output normal_zero,
                    output saturated, input ready);
    modport sink (input valid, input refl_x, input refl_y, input normal_zero,
                  input saturated, output ready);
endinterface

// ===== hw/rtl/vector_reflect_2d_top.sv =====
// top level of the 2d vector reflection block
// Reflects a Q16.16 velocity about a plane normal of any length: the normal is
// scaled to unit length (square root, then reciprocal), d = v.u is formed and
// v - 2*d*u comes out, clamped to 32 bits with the saturated flag; a zero normal
// passes the velocity through with normal_zero set. The datapath is one long
// pipeline that takes one item per clock while the output queue is not full
// and returns one result per item in order. Items pass the absolute values,
// prescale, squares and sum, a chain of 32 square root cells (one result bit
// each), a chain of 33 reciprocal cells (one quotient bit each), unit normal,
// dot product, multiply and clamp, then a 2-entry output queue. The whole
// pipeline moves on one enable that drops only when the output queue is full,
// so input ready stays high while a single result waits to be taken.
module vector_reflect_2d_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vr2d_in_if.sink    i_in,
    vr2d_out_if.source o_out
);

    // global pipeline advance
    logic en;

    // stage 0: absolute values of the normal
    logic                r_v0;
    vr2d_pkg::t_side     r_s0_side;
    logic [31:0]         r_s0_ax;
    logic [31:0]         r_s0_ay;

    // prescale: one fix-down stage, then five normalize shifts
    logic [vr2d_pkg::NORM_STEPS:0] r_nv;
    vr2d_pkg::t_side r_nm [0:vr2d_pkg::NORM_STEPS];
    vr2d_pkg::t_side n_nm [0:vr2d_pkg::NORM_STEPS];

    // squares and their sum
    logic            r_v_sqm;
    vr2d_pkg::t_side r_sqm_side;
    logic [61:0]     r_x2;
    logic [61:0]     r_y2;
    logic            r_v_sum;
    vr2d_pkg::t_side r_sum_side;
    logic [63:0]     r_sum;

    // cell chains
    logic          w_sqv [0:vr2d_pkg::SQRT_CELLS];
    vr2d_pkg::t_sq w_sq  [0:vr2d_pkg::SQRT_CELLS];
    logic          w_dvv [0:vr2d_pkg::DIV_CELLS];
    vr2d_pkg::t_dv w_dv  [0:vr2d_pkg::DIV_CELLS];

    // unit normal, dot product, reflection
    logic               r_v_u;
    vr2d_pkg::t_side    r_u_side;
    logic [29:0]        r_uxm;
    logic [29:0]        r_uym;
    logic [63:0]        w_mx;
    logic [63:0]        w_my;
    logic               r_v_un;
    vr2d_pkg::t_side    r_un_side;
    logic signed [30:0] r_ux;
    logic signed [30:0] r_uy;
    logic               r_v_p;
    vr2d_pkg::t_side    r_p_side;
    logic signed [30:0] r_p_ux;
    logic signed [30:0] r_p_uy;
    logic signed [62:0] r_px;
    logic signed [62:0] r_py;
    logic signed [63:0] w_p;
    logic               r_v_k;
    vr2d_pkg::t_side    r_k_side;
    logic signed [30:0] r_k_ux;
    logic signed [30:0] r_k_uy;
    logic signed [34:0] r_k;
    logic               r_v_t;
    vr2d_pkg::t_side    r_t_side;
    logic signed [63:0] r_tx;
    logic signed [63:0] r_ty;
    logic signed [34:0] w_tx;
    logic signed [34:0] w_ty;
    logic signed [35:0] w_rx;
    logic signed [35:0] w_ry;
    vr2d_pkg::t_res     w_res;
    logic               w_sat_x;
    logic               w_sat_y;
    logic               r_v_r;
    vr2d_pkg::t_res     r_res;

    // output queue
    vr2d_pkg::t_res r_q [0:1];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign en         = (r_cnt != 2'd2);
    assign i_in.ready = en;

    // ---------------------------------------------------------------- stage 0
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_side.vx    <= i_in.vel_x;
            r_s0_side.vy    <= i_in.vel_y;
            r_s0_side.ax    <= '0;
            r_s0_side.ay    <= '0;
            r_s0_side.neg_x <= i_in.normal_x[31];
            r_s0_side.neg_y <= i_in.normal_y[31];
            r_s0_side.zero  <= (i_in.normal_x == '0) && (i_in.normal_y == '0);
            // abs of the most negative word is 2^31, still exact unsigned
            r_s0_ax <= i_in.normal_x[31] ? 32'(-i_in.normal_x) : 32'(i_in.normal_x);
            r_s0_ay <= i_in.normal_y[31] ? 32'(-i_in.normal_y) : 32'(i_in.normal_y);
        end
    end

    // --------------------------------------------------------------- prescale
    // the leading one of max(ax, ay) is the leading one of ax | ay
    always_comb begin
        logic [31:0] w_or32;
        logic [30:0] w_or;
        int          sh;
        w_or32 = r_s0_ax | r_s0_ay;
        n_nm[0] = r_s0_side;
        if (w_or32[31]) begin
            // a component of exactly 2^31: one truncating right shift
            n_nm[0].ax = 31'(r_s0_ax >> 1);
            n_nm[0].ay = 31'(r_s0_ay >> 1);
        end else begin
            n_nm[0].ax = r_s0_ax[30:0];
            n_nm[0].ay = r_s0_ay[30:0];
        end
        for (int g = 0; g < vr2d_pkg::NORM_STEPS; g++) begin
            sh = 16 >> g;
            w_or = r_nm[g].ax | r_nm[g].ay;
            n_nm[g+1] = r_nm[g];
            if ((w_or >> (31 - sh)) == '0) begin
                n_nm[g+1].ax = r_nm[g].ax << sh;
                n_nm[g+1].ay = r_nm[g].ay << sh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nm <= n_nm;
        end
    end

    // ------------------------------------------------------- squares and sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqm_side <= r_nm[vr2d_pkg::NORM_STEPS];
            r_x2 <= 62'(r_nm[vr2d_pkg::NORM_STEPS].ax) * 62'(r_nm[vr2d_pkg::NORM_STEPS].ax);
            r_y2 <= 62'(r_nm[vr2d_pkg::NORM_STEPS].ay) * 62'(r_nm[vr2d_pkg::NORM_STEPS].ay);
            r_sum_side <= r_sqm_side;
            r_sum      <= 64'(r_x2) + 64'(r_y2);
        end
    end

    // ------------------------------------------------------ square root chain
    assign w_sqv[0] = r_v_sum;
    assign w_sq[0]  = '{res: '0, rem: r_sum, side: r_sum_side};

    for (genvar g = 0; g < vr2d_pkg::SQRT_CELLS; g++) begin : g_sqrt
        vr2d_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bit   (64'(1) << (62 - 2 * g)),
            .i_v     (w_sqv[g]),
            .i_d     (w_sq[g]),
            .o_v     (w_sqv[g+1]),
            .o_d     (w_sq[g+1])
        );
    end

    // ------------------------------------------------------- reciprocal chain
    // rcp = floor(2^62 / mag), mag in [2^30, 2^31.5)
    assign w_dvv[0] = w_sqv[vr2d_pkg::SQRT_CELLS];
    assign w_dv[0]  = '{rem: vr2d_pkg::DIV_REM0, q: '0,
                        mag: w_sq[vr2d_pkg::SQRT_CELLS].res[31:0],
                        side: w_sq[vr2d_pkg::SQRT_CELLS].side};

    for (genvar g = 0; g < vr2d_pkg::DIV_CELLS; g++) begin : g_div
        vr2d_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_v     (w_dvv[g]),
            .i_d     (w_dv[g]),
            .o_v     (w_dvv[g+1]),
            .o_d     (w_dv[g+1])
        );
    end

    // ------------------------------------------------- unit normal and dot
    assign w_mx = 64'(w_dv[vr2d_pkg::DIV_CELLS].side.ax) * 64'(w_dv[vr2d_pkg::DIV_CELLS].q);
    assign w_my = 64'(w_dv[vr2d_pkg::DIV_CELLS].side.ay) * 64'(w_dv[vr2d_pkg::DIV_CELLS].q);
    assign w_p  = 64'(r_px) + 64'(r_py);

    always_ff @(posedge i_clk) begin
        if (en) begin
            // magnitude of the unit normal, UNIT_BITS fraction bits, at most 2^29
            r_u_side <= w_dv[vr2d_pkg::DIV_CELLS].side;
            r_uxm    <= 30'(w_mx >> (62 - vr2d_pkg::UNIT_BITS));
            r_uym    <= 30'(w_my >> (62 - vr2d_pkg::UNIT_BITS));

            r_un_side <= r_u_side;
            r_ux <= r_u_side.neg_x ? -$signed({1'b0, r_uxm}) : $signed({1'b0, r_uxm});
            r_uy <= r_u_side.neg_y ? -$signed({1'b0, r_uym}) : $signed({1'b0, r_uym});

            r_p_side <= r_un_side;
            r_p_ux   <= r_ux;
            r_p_uy   <= r_uy;
            r_px     <= r_un_side.vx * r_ux;
            r_py     <= r_un_side.vy * r_uy;

            // twice the dot: floor shift by UNIT_BITS-1
            r_k_side <= r_p_side;
            r_k_ux   <= r_p_ux;
            r_k_uy   <= r_p_uy;
            r_k      <= w_p[62:vr2d_pkg::UNIT_BITS-1];

            r_t_side <= r_k_side;
            r_tx     <= r_k * r_k_ux;
            r_ty     <= r_k * r_k_uy;

            r_res <= w_res;
        end
    end

    // ---------------------------------------------------------- subtract, clamp
    always_comb begin
        w_tx = r_tx[63:vr2d_pkg::UNIT_BITS];
        w_ty = r_ty[63:vr2d_pkg::UNIT_BITS];
        w_rx = 36'(r_t_side.vx) - 36'(w_tx);
        w_ry = 36'(r_t_side.vy) - 36'(w_ty);
        w_sat_x = (w_rx[35:31] != {5{w_rx[35]}});
        w_sat_y = (w_ry[35:31] != {5{w_ry[35]}});
        w_res.normal_zero = r_t_side.zero;
        if (r_t_side.zero) begin
            // zero normal: velocity passes through
            w_res.refl_x    = r_t_side.vx;
            w_res.refl_y    = r_t_side.vy;
            w_res.saturated = 1'b0;
        end else begin
            if (w_sat_x) begin
                w_res.refl_x = w_rx[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                w_res.refl_x = w_rx[31:0];
            end
            if (w_sat_y) begin
                w_res.refl_y = w_ry[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                w_res.refl_y = w_ry[31:0];
            end
            w_res.saturated = w_sat_x || w_sat_y;
        end
    end

    // ------------------------------------------------------------ valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_nv    <= '0;
            r_v_sqm <= 1'b0;
            r_v_sum <= 1'b0;
            r_v_u   <= 1'b0;
            r_v_un  <= 1'b0;
            r_v_p   <= 1'b0;
            r_v_k   <= 1'b0;
            r_v_t   <= 1'b0;
            r_v_r   <= 1'b0;
        end else if (en) begin
            r_v0    <= i_in.valid;
            r_nv    <= {r_nv[vr2d_pkg::NORM_STEPS-1:0], r_v0};
            r_v_sqm <= r_nv[vr2d_pkg::NORM_STEPS];
            r_v_sum <= r_v_sqm;
            r_v_u   <= w_dvv[vr2d_pkg::DIV_CELLS];
            r_v_un  <= r_v_u;
            r_v_p   <= r_v_un;
            r_v_k   <= r_v_p;
            r_v_t   <= r_v_k;
            r_v_r   <= r_v_t;
        end
    end

    // ------------------------------------------------------------ output queue
    assign w_push = en && r_v_r;
    assign w_pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= r_res;
        end
    end

    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.refl_x      = r_q[r_rptr].refl_x;
    assign o_out.refl_y      = r_q[r_rptr].refl_y;
    assign o_out.normal_zero = r_q[r_rptr].normal_zero;
    assign o_out.saturated   = r_q[r_rptr].saturated;

endmodule

// ===== hw/rtl/vr2d_sqrt_cell.sv =====
// one result bit of the pipelined integer square root
module vr2d_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [63:0]    i_bit,
    input  logic           i_v,
    input  vr2d_pkg::t_sq  i_d,
    output logic           o_v,
    output vr2d_pkg::t_sq  o_d
);

    logic          r_v;
    vr2d_pkg::t_sq r_d;
    vr2d_pkg::t_sq n_d;
    logic [63:0]   w_trial;

    always_comb begin
        w_trial = i_d.res + i_bit;
        n_d = i_d;
        if (i_d.rem >= w_trial) begin
            n_d.rem = i_d.rem - w_trial;
            n_d.res = (i_d.res >> 1) + i_bit;
        end else begin
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_v = r_v;
    assign o_d = r_d;

endmodule

// ===== hw/rtl/vr2d_div_cell.sv =====
// one quotient bit of the pipelined reciprocal
module vr2d_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_v,
    input  vr2d_pkg::t_dv  i_d,
    output logic           o_v,
    output vr2d_pkg::t_dv  o_d
);

    logic          r_v;
    vr2d_pkg::t_dv r_d;
    vr2d_pkg::t_dv n_d;
    logic [32:0]   w_shl;

    always_comb begin
        w_shl = {i_d.rem[31:0], 1'b0};
        n_d = i_d;
        if (w_shl >= {1'b0, i_d.mag}) begin
            n_d.rem = w_shl - {1'b0, i_d.mag};
            n_d.q   = {i_d.q[31:0], 1'b1};
        end else begin
            n_d.rem = w_shl;
            n_d.q   = {i_d.q[31:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_v = r_v;
    assign o_d = r_d;

endmodule

// ===== hw/rtl/vr2d_checker.sv =====
// port-level checks of the 2d vector reflection block
`include "vector_reflect_2d_top_defines.svh"

module vr2d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_refl_x,
    input logic [31:0] i_refl_y,
    input logic        i_normal_zero,
    input logic        i_saturated
);

    `VR2D_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_refl_x) && $stable(i_refl_y), "result changed while stalled")
    `VR2D_ASSERT_CLK(a_flags, i_clk, i_rst_n, i_out_valid |-> !(i_normal_zero && i_saturated), "zero normal result marked saturated")
    `VR2D_ASSERT_CLK(a_ready_stall, i_clk, i_rst_n, !i_in_ready |-> i_out_valid && !$past(i_out_ready), "input stalled without a waiting result")
    `VR2D_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result shown after reset")

endmodule

bind vector_reflect_2d_top vr2d_checker u_vr2d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_refl_x      (o_out.refl_x),
    .i_refl_y      (o_out.refl_y),
    .i_normal_zero (o_out.normal_zero),
    .i_saturated   (o_out.saturated)
);
